@@ design/mlptw_pkg.sv @@
// Package for the multilevel page table walker.
// Holds default parameter values, command and status codes, and the
// control and status structs shared by the controller and the datapath.
package mlptw_pkg;

  localparam int OFFSET_BITS_DEF = 12;
  localparam int WALK_LEVELS_DEF = 4;
  localparam int NUM_FRAMES_DEF  = 64;

  localparam int VA_W = 64;
  localparam int PA_W = 18;

  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_ALLOCATE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FAULT   = 2'd1,
    ST_NOFRAME = 2'd2
  } status_t;

  typedef struct packed {
    logic    clear_step;
    logic    load;
    logic    root_take;
    logic    walk_start;
    logic    mem_read;
    logic    walk_step;
    logic    out_load;
    status_t out_status;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic alloc;
    logic out_of_range;
    logic root_valid;
    logic frames_left;
    logic entry_valid;
    logic last_level;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ design/mlptw_if.sv @@
// Channel interfaces of the page table walker: command beats in, results out.
// Depends on mlptw_pkg for widths and the status type.
interface mlptw_in_if import mlptw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            command;
  logic [VA_W-1:0] virtual_address;

  modport source (output valid, output command, output virtual_address, input ready);
  modport sink   (input valid, input command, input virtual_address, output ready);
endinterface

interface mlptw_out_if import mlptw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PA_W-1:0] phys_addr;
  status_t         status;

  modport source (output valid, output phys_addr, output status, input ready);
  modport sink   (input valid, input phys_addr, input status, output ready);
endinterface

@@ design/mlptw_datapath.sv @@
// Datapath of the page table walker: table memory, frame allocator, walk
// registers and the output register. Depends on mlptw_pkg.
module mlptw_datapath import mlptw_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int WALK_LEVELS = WALK_LEVELS_DEF,
  parameter int NUM_FRAMES  = NUM_FRAMES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ctl_cmd_t        cmd,
  output dp_stat_t        stat,
  input  logic            in_command,
  input  logic [VA_W-1:0] in_virtual_address,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [PA_W-1:0] out_phys_addr,
  output status_t         out_status
);

  localparam int IDX_BITS = OFFSET_BITS - 3;
  localparam int FRAME_W  = $clog2(NUM_FRAMES);
  localparam int NFF_W    = $clog2(NUM_FRAMES + 1);
  localparam int ENTRY_W  = FRAME_W + 1;
  localparam int ADDR_W   = FRAME_W + IDX_BITS;
  localparam int DEPTH    = NUM_FRAMES * (2 ** IDX_BITS);
  localparam int VPN_W    = IDX_BITS * WALK_LEVELS;
  localparam int VA_BITS  = VPN_W + OFFSET_BITS;
  localparam int EXT_W    = (VA_BITS > VA_W) ? VA_BITS : VA_W;
  localparam int LVL_W    = (WALK_LEVELS > 1) ? $clog2(WALK_LEVELS) : 1;
  localparam logic [VA_W-1:0] HIGH_MASK =
    (VA_BITS >= VA_W) ? '0 : ~((VA_W'(1) << VA_BITS) - VA_W'(1));

  logic [ENTRY_W-1:0]     mem [DEPTH];
  logic [ENTRY_W-1:0]     rdata_r;
  logic [ADDR_W-1:0]      clr_cnt_r;
  logic [OFFSET_BITS-1:0] va_off_r;
  logic [VPN_W-1:0]       vpn_r;
  logic                   alloc_r;
  logic                   oor_r;
  logic [FRAME_W-1:0]     frame_r;
  logic [LVL_W-1:0]       lvl_r;
  logic                   root_valid_r;
  logic [FRAME_W-1:0]     root_frame_r;
  logic [NFF_W-1:0]       nff_r;
  logic                   out_valid_r;
  logic [PA_W-1:0]        out_pa_r;
  status_t                out_status_r;

  logic [EXT_W-1:0]               va_ext;
  logic [IDX_BITS-1:0]            idx;
  logic [ADDR_W-1:0]              mem_addr;
  logic                           mem_we;
  logic [ENTRY_W-1:0]             mem_wdata;
  logic [FRAME_W-1:0]             new_frame;
  logic [FRAME_W+OFFSET_BITS-1:0] pa_full;

  assign va_ext    = EXT_W'(in_virtual_address);
  assign idx       = vpn_r[VPN_W-1 -: IDX_BITS];
  assign new_frame = FRAME_W'(nff_r);
  assign mem_addr  = cmd.clear_step ? clr_cnt_r : {frame_r, idx};
  assign mem_we    = cmd.clear_step || (cmd.walk_step && !rdata_r[0]);
  assign mem_wdata = cmd.clear_step ? '0 : {new_frame, 1'b1};
  assign pa_full   = {frame_r, va_off_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.mem_read) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r    <= '0;
      root_valid_r <= 1'b0;
      root_frame_r <= '0;
      nff_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.root_take) begin
        root_valid_r <= 1'b1;
        root_frame_r <= new_frame;
      end
      if (cmd.root_take || (cmd.walk_step && !rdata_r[0])) begin
        nff_r <= nff_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      va_off_r <= in_virtual_address[OFFSET_BITS-1:0];
      vpn_r    <= va_ext[OFFSET_BITS +: VPN_W];
      alloc_r  <= (in_command == CMD_ALLOCATE);
      oor_r    <= |(in_virtual_address & HIGH_MASK);
      lvl_r    <= '0;
    end
    if (cmd.walk_start) begin
      frame_r <= cmd.root_take ? new_frame : root_frame_r;
    end
    if (cmd.walk_step) begin
      frame_r <= rdata_r[0] ? rdata_r[ENTRY_W-1:1] : new_frame;
      vpn_r   <= vpn_r << IDX_BITS;
      lvl_r   <= lvl_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_pa_r     <= (cmd.out_status == ST_OK) ? PA_W'(pa_full) : '0;
      out_status_r <= cmd.out_status;
    end
  end

  always_comb begin
    stat.clear_done   = (clr_cnt_r == ADDR_W'(DEPTH - 1));
    stat.alloc        = alloc_r;
    stat.out_of_range = oor_r;
    stat.root_valid   = root_valid_r;
    stat.frames_left  = (nff_r != NFF_W'(NUM_FRAMES));
    stat.entry_valid  = rdata_r[0];
    stat.last_level   = (lvl_r == LVL_W'(WALK_LEVELS - 1));
    stat.out_busy     = out_valid_r && !out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_phys_addr = out_pa_r;
  assign out_status    = out_status_r;

endmodule

@@ design/mlptw_ctrl.sv @@
// Controller state machine of the page table walker: clearing pass, root
// check, per-level read and evaluate steps, result hand-off. Uses mlptw_pkg.
module mlptw_ctrl import mlptw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROOT,
    S_READ,
    S_EVAL,
    S_DONE
  } state_t;

  state_t  state_r;
  state_t  state_nxt;
  status_t status_r;
  status_t status_nxt;

  always_comb begin
    cmd            = '0;
    cmd.out_status = status_r;
    state_nxt      = state_r;
    status_nxt     = status_r;
    in_ready       = (state_r == S_IDLE);
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          status_nxt = ST_OK;
          state_nxt  = S_ROOT;
        end
      end
      S_ROOT: begin
        if (stat.out_of_range) begin
          status_nxt = ST_FAULT;
          state_nxt  = S_DONE;
        end else if (stat.root_valid) begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_READ;
        end else if (!stat.alloc) begin
          status_nxt = ST_FAULT;
          state_nxt  = S_DONE;
        end else if (!stat.frames_left) begin
          status_nxt = ST_NOFRAME;
          state_nxt  = S_DONE;
        end else begin
          cmd.root_take  = 1'b1;
          cmd.walk_start = 1'b1;
          state_nxt      = S_READ;
        end
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_nxt    = S_EVAL;
      end
      S_EVAL: begin
        if (stat.entry_valid || (stat.alloc && stat.frames_left)) begin
          cmd.walk_step = 1'b1;
          state_nxt     = stat.last_level ? S_DONE : S_READ;
        end else if (!stat.alloc) begin
          status_nxt = ST_FAULT;
          state_nxt  = S_DONE;
        end else begin
          status_nxt = ST_NOFRAME;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

@@ design/multilevel_page_table_walker.sv @@
// Radix page table walker with frame allocation, top level.
// A full walk reads and evaluates one table entry per level for WALK_LEVELS levels;
// an out-of-range address or a missing root that cannot be allocated skips the walk.
// One item is walked at a time, paced by the read and evaluate steps of the table
// memory at each level; a waiting result does not hold off acceptance of the next command.
// Reset clears all NUM_FRAMES*2^(OFFSET_BITS-3) table entries (32768 by default).
module multilevel_page_table_walker import mlptw_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int WALK_LEVELS = WALK_LEVELS_DEF,
  parameter int NUM_FRAMES  = NUM_FRAMES_DEF
) (
  input logic         clk,
  input logic         rst_n,
  mlptw_in_if.sink    in_ch,
  mlptw_out_if.source out_ch
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  mlptw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mlptw_datapath #(
    .OFFSET_BITS (OFFSET_BITS),
    .WALK_LEVELS (WALK_LEVELS),
    .NUM_FRAMES  (NUM_FRAMES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_command         (in_ch.command),
    .in_virtual_address (in_ch.virtual_address),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_phys_addr      (out_ch.phys_addr),
    .out_status         (out_ch.status)
  );

endmodule

@@ design/mlptw_checker.sv @@
// Port-level checker for the page table walker and its bind to the top level.
// Depends on mlptw_pkg for the status codes.
module mlptw_checker import mlptw_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [PA_W-1:0] out_pa,
  input logic [1:0]      out_status
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pa) && $stable(out_status))
    else $error("result beat changed while stalled");

  // A failed command reports address zero.
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_pa == '0)
    else $error("nonzero address with error status");

  // Reset starts the clearing pass, so no command is taken right after it.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("command port ready right after reset");

  // Only one command is in the walker at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken during a walk");

endmodule

bind multilevel_page_table_walker mlptw_checker u_mlptw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_pa     (out_ch.phys_addr),
  .out_status (out_ch.status)
);
